>>> design/delt_pkg.sv
// Shared types and codes for the deduplicating event log table.
// Depends on nothing; used by dedup_event_log_table_unit.
package delt_pkg;

   localparam int unsigned TABLE_DEPTH_DEFAULT = 64;
   localparam int unsigned READ_INDEX_W        = 6;
   localparam int unsigned ENTRY_POS_W         = 6;
   localparam int unsigned ENTRIES_USED_W      = 7;

   // Request kinds
   localparam logic [1:0] KIND_LOG   = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // Response status codes
   localparam logic [2:0] STATUS_NEW     = 3'd0;
   localparam logic [2:0] STATUS_MERGED  = 3'd1;
   localparam logic [2:0] STATUS_FULL    = 3'd2;
   localparam logic [2:0] STATUS_READ_OK = 3'd3;
   localparam logic [2:0] STATUS_EMPTY   = 3'd4;

   typedef struct packed {
      logic [31:0] source_addr;
      logic [31:0] dest_addr;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [7:0]  proto;
      logic [7:0]  verdict;
      logic [7:0]  why_code;
   } key_type;

   typedef struct packed {
      key_type     key;
      logic [31:0] last_time;
      logic [31:0] hits;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_RESP
   } state_type;

endpackage

>>> design/dedup_event_log_table_unit.sv
// Deduplicating event log table: top level, entry memory and search sequencer.
// Depends on delt_pkg for entry types, request kinds, status codes and states.
//
// Usage
//   Request channel (req_*): one transaction carries a kind and a full event.
//   Log events search the stored entries in insertion order with one shared
//   key comparator, one entry per cycle, fed by a single-port read of the
//   entry memory. A hit refreshes the timestamp and bumps the saturating hit
//   count; a miss appends; a miss on a full table is dropped and flagged.
//   Reads fetch one entry by position; a clear empties the table at once.
//   Response channel (rsp_*): exactly one transaction per request, taken
//   from an output register.
// Timing
//   The search loop over the memory read port sets the time a log event
//   takes, up to a pass over all valid entries; an early hit ends it sooner.
//   Reads, clears and unused kinds take no search. This is with a ready receiver.
//   The block handles one transaction at a time; req_ready is low meanwhile.
// Reset
//   Synchronous reset empties the table; memory contents are left as they are
//   and are never read before being written. A stalled receiver holds the
//   response, and no new request is taken until it has been delivered.
module dedup_event_log_table_unit #(
   parameter int unsigned TABLE_DEPTH = delt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [31:0]        req_event_time,
   input  logic [7:0]         req_proto,
   input  logic [7:0]         req_verdict,
   input  logic [31:0]        req_source_addr,
   input  logic [31:0]        req_dest_addr,
   input  logic [15:0]        req_source_port,
   input  logic [15:0]        req_dest_port,
   input  logic signed [7:0]  req_why_code,
   input  logic [5:0]         req_read_index,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [5:0]         rsp_entry_pos,
   output logic [6:0]         rsp_entries_used,
   output logic [31:0]        rsp_out_time,
   output logic [7:0]         rsp_out_proto,
   output logic [7:0]         rsp_out_verdict,
   output logic [31:0]        rsp_out_source_addr,
   output logic [31:0]        rsp_out_dest_addr,
   output logic [15:0]        rsp_out_source_port,
   output logic [15:0]        rsp_out_dest_port,
   output logic signed [7:0]  rsp_out_why_code,
   output logic [31:0]        rsp_hit_count
);

   localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned CMP_W = CNT_W + delt_pkg::READ_INDEX_W;
   localparam int unsigned POS_W = delt_pkg::ENTRY_POS_W;
   localparam int unsigned USE_W = delt_pkg::ENTRIES_USED_W;

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   delt_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]    used_ff, used_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;        // next entry to fetch
   logic                cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;  // entry now in rd_data_ff

   delt_pkg::entry_type req_entry_ff;   // latched event: key and time
   logic [5:0]          req_index_ff;

   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [USE_W-1:0]    rsp_used_ff, rsp_used_in;
   delt_pkg::entry_type rsp_entry_ff, rsp_entry_in;
   logic                rsp_load;

   // Entry memory: one write and one registered read port
   delt_pkg::entry_type mem [TABLE_DEPTH];
   delt_pkg::entry_type rd_data_ff;
   logic                mem_re, mem_we;
   logic [IDX_W-1:0]    mem_raddr, mem_waddr;
   delt_pkg::entry_type mem_wdata;

   // ------------------------------------------------------------------
   // Shared compare unit and helpers
   // ------------------------------------------------------------------
   delt_pkg::entry_type req_port_entry;
   logic                key_match;
   logic                scan_done;
   logic                table_full;
   logic                index_in_range;
   logic                req_fire;
   logic [31:0]         hits_bumped;

   always_comb begin
      req_port_entry.key.source_addr = req_source_addr;
      req_port_entry.key.dest_addr   = req_dest_addr;
      req_port_entry.key.source_port = req_source_port;
      req_port_entry.key.dest_port   = req_dest_port;
      req_port_entry.key.proto       = req_proto;
      req_port_entry.key.verdict     = req_verdict;
      req_port_entry.key.why_code    = $unsigned(req_why_code);
      req_port_entry.last_time       = req_event_time;
      req_port_entry.hits            = 32'd1;
   end

   assign key_match      = cmp_valid_ff && (rd_data_ff.key == req_entry_ff.key);
   assign scan_done      = (ptr_ff == used_ff);
   assign table_full     = (used_ff == CNT_W'(TABLE_DEPTH));
   assign index_in_range = (CMP_W'(req_read_index) < CMP_W'(used_ff));
   assign req_fire       = req_valid && req_ready;
   assign hits_bumped    = (rd_data_ff.hits == '1) ? rd_data_ff.hits
                                                   : rd_data_ff.hits + 32'd1;

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         delt_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == delt_pkg::KIND_LOG) begin
                  state_in = delt_pkg::ST_SCAN;
               end else if (req_kind == delt_pkg::KIND_READ && index_in_range) begin
                  state_in = delt_pkg::ST_FETCH;
               end else begin
                  state_in = delt_pkg::ST_RESP;
               end
            end
         end
         delt_pkg::ST_SCAN: begin
            if (key_match || scan_done) begin
               state_in = delt_pkg::ST_RESP;
            end
         end
         delt_pkg::ST_FETCH: begin
            state_in = delt_pkg::ST_RESP;
         end
         delt_pkg::ST_RESP: begin
            if (rsp_ready) begin
               state_in = delt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = delt_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Outputs and datapath controls
   // ------------------------------------------------------------------
   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      used_in       = used_ff;
      ptr_in        = ptr_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_idx_in    = cmp_idx_ff;
      mem_re        = 1'b0;
      mem_raddr     = ptr_ff[IDX_W-1:0];
      mem_we        = 1'b0;
      mem_waddr     = cmp_idx_ff;
      mem_wdata     = req_entry_ff;
      rsp_load      = 1'b0;
      rsp_status_in = delt_pkg::STATUS_EMPTY;
      rsp_pos_in    = '0;
      rsp_used_in   = USE_W'(used_ff);
      rsp_entry_in  = '0;

      case (state_ff)
         delt_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            ptr_in       = '0;
            cmp_valid_in = 1'b0;
            if (req_valid) begin
               case (req_kind)
                  delt_pkg::KIND_LOG: begin
                     // search starts next cycle
                  end
                  delt_pkg::KIND_READ: begin
                     if (index_in_range) begin
                        mem_re    = 1'b1;
                        mem_raddr = IDX_W'(req_read_index);
                     end else begin
                        rsp_load   = 1'b1;
                        rsp_pos_in = POS_W'(req_read_index);
                     end
                  end
                  delt_pkg::KIND_CLEAR: begin
                     used_in     = '0;
                     rsp_load    = 1'b1;
                     rsp_used_in = '0;
                  end
                  default: begin
                     // unused kind: report the table as it stands
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end

         delt_pkg::ST_SCAN: begin
            if (key_match) begin
               // hit: refresh time, bump the count, write back in place
               mem_we                 = 1'b1;
               mem_waddr              = cmp_idx_ff;
               mem_wdata              = rd_data_ff;
               mem_wdata.last_time    = req_entry_ff.last_time;
               mem_wdata.hits         = hits_bumped;
               rsp_load               = 1'b1;
               rsp_status_in          = delt_pkg::STATUS_MERGED;
               rsp_pos_in             = POS_W'(cmp_idx_ff);
               rsp_entry_in           = mem_wdata;
            end else if (!scan_done) begin
               // fetch the next entry for the comparator
               mem_re       = 1'b1;
               mem_raddr    = ptr_ff[IDX_W-1:0];
               ptr_in       = ptr_ff + 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = ptr_ff[IDX_W-1:0];
            end else if (table_full) begin
               rsp_load      = 1'b1;
               rsp_status_in = delt_pkg::STATUS_FULL;
            end else begin
               // miss: append with a count of one
               mem_we        = 1'b1;
               mem_waddr     = used_ff[IDX_W-1:0];
               mem_wdata     = req_entry_ff;
               used_in       = used_ff + 1'b1;
               rsp_load      = 1'b1;
               rsp_status_in = delt_pkg::STATUS_NEW;
               rsp_pos_in    = POS_W'(used_ff);
               rsp_used_in   = USE_W'(used_in);
               rsp_entry_in  = req_entry_ff;
            end
         end

         delt_pkg::ST_FETCH: begin
            rsp_load      = 1'b1;
            rsp_status_in = delt_pkg::STATUS_READ_OK;
            rsp_pos_in    = POS_W'(req_index_ff);
            rsp_entry_in  = rd_data_ff;
         end

         delt_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end

         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= delt_pkg::ST_IDLE;
         used_ff      <= '0;
         ptr_ff       <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         ptr_ff       <= ptr_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      cmp_idx_ff <= cmp_idx_in;
      if (req_fire) begin
         req_entry_ff <= req_port_entry;
         req_index_ff <= req_read_index;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_used_ff   <= rsp_used_in;
         rsp_entry_ff  <= rsp_entry_in;
      end
   end

   // Entry memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // ------------------------------------------------------------------
   // Response ports
   // ------------------------------------------------------------------
   assign rsp_status          = rsp_status_ff;
   assign rsp_entry_pos       = rsp_pos_ff;
   assign rsp_entries_used    = rsp_used_ff;
   assign rsp_out_time        = rsp_entry_ff.last_time;
   assign rsp_out_proto       = rsp_entry_ff.key.proto;
   assign rsp_out_verdict     = rsp_entry_ff.key.verdict;
   assign rsp_out_source_addr = rsp_entry_ff.key.source_addr;
   assign rsp_out_dest_addr   = rsp_entry_ff.key.dest_addr;
   assign rsp_out_source_port = rsp_entry_ff.key.source_port;
   assign rsp_out_dest_port   = rsp_entry_ff.key.dest_port;
   assign rsp_out_why_code    = $signed(rsp_entry_ff.key.why_code);
   assign rsp_hit_count       = rsp_entry_ff.hits;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   a_scan_ptr_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == delt_pkg::ST_SCAN |-> ptr_ff <= used_ff)
      else $error("search pointer ran past the valid entries");

   a_write_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == delt_pkg::ST_SCAN && !req_ready)
      else $error("entry memory written outside a search");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == delt_pkg::ST_SCAN && rsp_load &&
       rsp_status_in == delt_pkg::STATUS_NEW)
      |=> used_ff == $past(used_ff) + 1'b1)
      else $error("append did not grow the table by one");

   a_merged_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == delt_pkg::STATUS_MERGED |-> rsp_hit_count != 32'd0)
      else $error("merged entry reports a zero hit count");

endmodule
